@@ rtl/rvx_pkg.sv @@
// shared types, codes and constants for the rv32im execute core
// no dependencies; imported by every module of the core
package rvx_pkg;

    localparam int XLEN   = 32;
    localparam int NREGS  = 32;
    localparam int RIDX_W = 5;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0]  F7_BASE   = 7'h00;
    localparam logic [6:0]  F7_ALT    = 7'h20;
    localparam logic [6:0]  F7_MULDIV = 7'h01;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [1:0] KIND_RETIRE = 2'd0;
    localparam logic [1:0] KIND_MEMREQ = 2'd1;
    localparam logic [1:0] KIND_HALT   = 2'd2;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_ILLEGAL = 2'd1;
    localparam logic [1:0] CAUSE_MEMFLT  = 2'd2;
    localparam logic [1:0] CAUSE_ECALL   = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef enum logic [3:0] {
        CL_LUI, CL_AUIPC, CL_JAL, CL_JALR, CL_BRANCH, CL_LOAD, CL_STORE,
        CL_OPIMM, CL_OP, CL_MULDIV, CL_SYSTEM, CL_ILLEGAL
    } t_cls;

    typedef struct packed {
        logic        req_type;
        logic [31:0] instr_word;
        logic [31:0] mem_rdata;
        logic        mem_ok;
        t_cls        cls;
    } t_qent;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  halt_cause;
        logic [31:0] next_pc;
        logic [31:0] mem_addr;
        logic        mem_is_write;
        logic [1:0]  mem_size_log2;
        logic [31:0] store_data;
    } t_result;

endpackage

@@ rtl/rvx_front.sv @@
// front end: two-entry queue that accepts items and tags each with its class
// depends on rvx_pkg
module rvx_front import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_mem_rdata,
    input  logic        i_mem_ok,
    output logic        o_head_valid,
    output t_qent       o_head,
    input  logic        i_pop
);

    t_qent      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cls       cls;
    logic       push;

    always_comb begin
        unique case (i_instr_word[6:0])
            OPC_LUI:    cls = CL_LUI;
            OPC_AUIPC:  cls = CL_AUIPC;
            OPC_JAL:    cls = CL_JAL;
            OPC_JALR:   cls = CL_JALR;
            OPC_BRANCH: cls = CL_BRANCH;
            OPC_LOAD:   cls = CL_LOAD;
            OPC_STORE:  cls = CL_STORE;
            OPC_OPIMM:  cls = CL_OPIMM;
            OPC_OP:     cls = (i_instr_word[31:25] == F7_MULDIV) ? CL_MULDIV : CL_OP;
            OPC_SYSTEM: cls = CL_SYSTEM;
            default:    cls = CL_ILLEGAL;
        endcase
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= '{req_type: i_req_type, instr_word: i_instr_word,
                             mem_rdata: i_mem_rdata, mem_ok: i_mem_ok, cls: cls};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/rvx_muldiv.sv @@
// multiply and divide unit: one registered 33x33 multiply, or 32-step restoring divide
// depends on rvx_pkg
module rvx_muldiv import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_req     i_req,
    output logic        o_done,
    output logic [31:0] o_res
);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_MUL  = 5'b00010,
        MD_DIV  = 5'b00100,
        MD_FIX  = 5'b01000,
        MD_DONE = 5'b10000
    } t_md_st;

    t_md_st       r_st;
    logic [2:0]   r_op;
    logic [65:0]  r_prod;
    logic [31:0]  r_rem, r_quo, r_den, r_res;
    logic [4:0]   r_cnt;
    logic         r_neg_q, r_neg_r;
    logic         a_sgn, b_sgn, sgn_div;
    logic [31:0]  a_mag, b_mag;
    logic [32:0]  shifted, diff;

    assign a_sgn   = (i_req.op[1:0] == 2'd1) || (i_req.op[1:0] == 2'd2);
    assign b_sgn   = (i_req.op[1:0] == 2'd1);
    assign sgn_div = !i_req.op[0];
    assign a_mag   = (sgn_div && i_req.a[31]) ? 32'd0 - i_req.a : i_req.a;
    assign b_mag   = (sgn_div && i_req.b[31]) ? 32'd0 - i_req.b : i_req.b;
    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_done  = (r_st == MD_DONE);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= MD_IDLE;
        end else begin
            unique case (r_st)
                MD_IDLE: begin
                    if (i_req.start) begin
                        if (!i_req.op[2]) r_st <= MD_MUL;
                        else if (i_req.b == 32'd0) r_st <= MD_DONE;
                        else r_st <= MD_DIV;
                    end
                end
                MD_MUL:  r_st <= MD_DONE;
                MD_DIV:  if (r_cnt == 5'd31) r_st <= MD_FIX;
                MD_FIX:  r_st <= MD_DONE;
                MD_DONE: r_st <= MD_IDLE;
                default: r_st <= MD_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            MD_IDLE: begin
                r_op    <= i_req.op;
                r_prod  <= 66'($signed({a_sgn && i_req.a[31], i_req.a})
                              * $signed({b_sgn && i_req.b[31], i_req.b}));
                r_rem   <= 32'd0;
                r_quo   <= a_mag;
                r_den   <= b_mag;
                r_cnt   <= 5'd0;
                r_neg_q <= sgn_div && (i_req.a[31] ^ i_req.b[31]);
                r_neg_r <= sgn_div && i_req.a[31];
                // divide by zero: quotient all ones, remainder the dividend
                r_res   <= i_req.op[1] ? i_req.a : '1;
            end
            MD_MUL: r_res <= (r_op[1:0] == 2'd0) ? r_prod[31:0] : r_prod[63:32];
            MD_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (!diff[32]) begin
                    r_rem <= diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= shifted[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            MD_FIX: begin
                if (r_op[1]) r_res <= r_neg_r ? 32'd0 - r_rem : r_rem;
                else         r_res <= r_neg_q ? 32'd0 - r_quo : r_quo;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/rvx_back.sv @@
// back end: sequencer, register file, alu and result register
// depends on rvx_pkg and rvx_muldiv
module rvx_back import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_head_valid,
    input  t_qent       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MD   = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_WAIT = 5'b10000
    } t_st;

    t_st               r_st;
    t_qent             r_item;
    logic [31:0]       r_rf [NREGS];
    logic [NREGS-1:0]  r_rf_vld;
    logic [31:0]       r_a_raw, r_b_raw;
    logic              r_a_vld, r_b_vld;
    logic [31:0]       r_pc;
    logic              r_pend, r_halted;
    logic [4:0]        r_pend_rd;
    logic [2:0]        r_pend_sz;
    logic [1:0]        r_cause;
    t_result           r_out;

    t_md_req     md_req;
    logic        md_done;
    logic [31:0] md_res;

    logic [31:0] w, a, b, pc4, immi, imms, immb, immj, immu, opb, alu, addr, ldv;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        emit, halt, to_md, wr_en, alu_ok, take, set_pend;
    logic [1:0]  hcause;
    logic [31:0] wr_val, npc;
    t_result     res;

    assign w    = r_item.instr_word;
    assign f3   = w[14:12];
    assign rd   = w[11:7];
    assign a    = r_a_vld ? r_a_raw : 32'd0;
    assign b    = r_b_vld ? r_b_raw : 32'd0;
    assign pc4  = r_pc + 32'd4;
    assign immi = {{20{w[31]}}, w[31:20]};
    assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign immu = {w[31:12], 12'd0};
    assign opb  = (r_item.cls == CL_OPIMM) ? immi : b;
    assign addr = a + ((r_item.cls == CL_STORE) ? imms : immi);

    // shared alu for register and immediate forms
    always_comb begin
        logic alt;
        alt    = w[30];
        alu_ok = 1'b1;
        alu    = 32'd0;
        if (r_item.cls == CL_OP) begin
            alu_ok = (w[31:25] == F7_BASE)
                  || (w[31:25] == F7_ALT && (f3 == 3'd0 || f3 == 3'd5));
        end else begin
            alt = 1'b0;
            if (f3 == 3'd1) alu_ok = (w[31:25] == F7_BASE);
            if (f3 == 3'd5) begin
                alu_ok = (w[31:25] == F7_BASE) || (w[31:25] == F7_ALT);
                alt    = w[30];
            end
        end
        unique case (f3)
            3'd0: alu = alt ? a - opb : a + opb;
            3'd1: alu = a << opb[4:0];
            3'd2: alu = {31'd0, $signed(a) < $signed(opb)};
            3'd3: alu = {31'd0, a < opb};
            3'd4: alu = a ^ opb;
            3'd5: alu = alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
            3'd6: alu = a | opb;
            3'd7: alu = a & opb;
            default: alu = 32'd0;
        endcase
    end

    always_comb begin
        unique case (r_pend_sz[1:0])
            SZ_BYTE: ldv = r_pend_sz[2] ? {24'd0, r_item.mem_rdata[7:0]}
                                        : {{24{r_item.mem_rdata[7]}}, r_item.mem_rdata[7:0]};
            SZ_HALF: ldv = r_pend_sz[2] ? {16'd0, r_item.mem_rdata[15:0]}
                                        : {{16{r_item.mem_rdata[15]}}, r_item.mem_rdata[15:0]};
            default: ldv = r_item.mem_rdata;
        endcase
    end

    // execute decision for the held transaction
    always_comb begin
        logic t;
        emit     = 1'b0;
        halt     = 1'b0;
        hcause   = CAUSE_ILLEGAL;
        to_md    = 1'b0;
        wr_en    = 1'b0;
        wr_val   = 32'd0;
        npc      = pc4;
        set_pend = 1'b0;
        t        = 1'b0;
        res      = '0;
        if (r_halted) begin
            emit = 1'b1;
            npc  = r_pc;
            res.result_kind = KIND_HALT;
            res.halt_cause  = r_cause;
        end else if (r_item.req_type) begin
            if (r_pend) begin
                emit = 1'b1;
                npc  = r_pc;
                if (!r_item.mem_ok) begin
                    halt   = 1'b1;
                    hcause = CAUSE_MEMFLT;
                end else begin
                    wr_en  = (r_pend_rd != 5'd0);
                    wr_val = ldv;
                end
            end
        end else if (!r_pend) begin
            emit = 1'b1;
            unique case (r_item.cls)
                CL_LUI:   begin wr_en = 1'b1; wr_val = immu; end
                CL_AUIPC: begin wr_en = 1'b1; wr_val = r_pc + immu; end
                CL_JAL:   begin wr_en = 1'b1; wr_val = pc4; npc = r_pc + immj; end
                CL_JALR: begin
                    if (f3 != 3'd0) halt = 1'b1;
                    else begin
                        wr_en  = 1'b1;
                        wr_val = pc4;
                        npc    = (a + immi) & ~32'd1;
                    end
                end
                CL_BRANCH: begin
                    unique case (f3)
                        3'd0: t = (a == b);
                        3'd1: t = (a != b);
                        3'd4: t = $signed(a) < $signed(b);
                        3'd5: t = !($signed(a) < $signed(b));
                        3'd6: t = a < b;
                        3'd7: t = a >= b;
                        default: halt = 1'b1;
                    endcase
                    if (t) npc = r_pc + immb;
                end
                CL_LOAD: begin
                    if (f3[1:0] == 2'd3 || f3 == 3'd6) halt = 1'b1;
                    else begin
                        set_pend = 1'b1;
                        res.result_kind   = KIND_MEMREQ;
                        res.mem_addr      = addr;
                        res.mem_size_log2 = f3[1:0];
                    end
                end
                CL_STORE: begin
                    if (f3 > 3'd2) halt = 1'b1;
                    else begin
                        set_pend = 1'b1;
                        res.result_kind   = KIND_MEMREQ;
                        res.mem_addr      = addr;
                        res.mem_is_write  = 1'b1;
                        res.mem_size_log2 = f3[1:0];
                        res.store_data    = (f3[1:0] == SZ_BYTE) ? {24'd0, b[7:0]}
                                          : (f3[1:0] == SZ_HALF) ? {16'd0, b[15:0]} : b;
                    end
                end
                CL_OPIMM, CL_OP: begin
                    if (!alu_ok) halt = 1'b1;
                    else begin wr_en = 1'b1; wr_val = alu; end
                end
                CL_MULDIV: begin emit = 1'b0; to_md = 1'b1; end
                CL_SYSTEM: begin
                    halt   = 1'b1;
                    hcause = (w == ECALL_WORD) ? CAUSE_ECALL : CAUSE_ILLEGAL;
                end
                default: halt = 1'b1;
            endcase
            if (rd == 5'd0) wr_en = 1'b0;
        end
        if (halt) begin
            wr_en    = 1'b0;
            set_pend = 1'b0;
            res      = '0;
            res.result_kind = KIND_HALT;
            res.halt_cause  = hcause;
        end
        res.next_pc = npc;
    end

    assign take   = (r_st == ST_IDLE) && i_head_valid;
    assign o_pop  = take;
    assign o_valid = (r_st == ST_OUT);
    assign o_res  = r_out;

    assign md_req.start = (r_st == ST_EXEC) && to_md;
    assign md_req.op    = f3;
    assign md_req.a     = a;
    assign md_req.b     = b;

    rvx_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    // register file: two registered reads, one write
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item  <= i_head;
            r_a_raw <= r_rf[i_head.instr_word[19:15]];
            r_b_raw <= r_rf[i_head.instr_word[24:20]];
        end
        if (r_st == ST_EXEC && wr_en) r_rf[r_item.req_type ? r_pend_rd : rd] <= wr_val;
        if (r_st == ST_MD && md_done && rd != 5'd0) r_rf[rd] <= md_res;
        if (r_st == ST_EXEC) r_out <= res;
        if (r_st == ST_MD) begin
            r_out <= '{result_kind: KIND_RETIRE, halt_cause: CAUSE_NONE, next_pc: pc4,
                       mem_addr: 32'd0, mem_is_write: 1'b0, mem_size_log2: SZ_BYTE,
                       store_data: 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_rf_vld  <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_pc      <= 32'd0;
            r_pend    <= 1'b0;
            r_pend_rd <= 5'd0;
            r_pend_sz <= 3'd0;
            r_halted  <= 1'b0;
            r_cause   <= CAUSE_NONE;
        end else begin
            if (i_cfg_we) r_pc <= i_cfg_data;
            if (take) begin
                r_a_vld <= r_rf_vld[i_head.instr_word[19:15]];
                r_b_vld <= r_rf_vld[i_head.instr_word[24:20]];
            end
            unique case (r_st)
                ST_IDLE: if (take) r_st <= ST_EXEC;
                ST_EXEC: begin
                    if (wr_en) r_rf_vld[r_item.req_type ? r_pend_rd : rd] <= 1'b1;
                    if (!r_halted) begin
                        if (r_item.req_type && r_pend) r_pend <= 1'b0;
                        if (emit && !r_item.req_type) r_pc <= npc;
                        if (set_pend) begin
                            r_pend    <= 1'b1;
                            r_pend_rd <= (r_item.cls == CL_STORE) ? 5'd0 : rd;
                            r_pend_sz <= {f3[2], f3[1:0]};
                        end
                        if (halt) begin
                            r_halted <= 1'b1;
                            r_cause  <= hcause;
                        end
                    end
                    if (to_md && !r_halted && !r_item.req_type && !r_pend) r_st <= ST_MD;
                    else if (emit) r_st <= ST_OUT;
                    else r_st <= ST_IDLE;
                end
                ST_MD: begin
                    if (md_done) begin
                        if (rd != 5'd0) r_rf_vld[rd] <= 1'b1;
                        r_pc <= pc4;
                        r_st <= ST_WAIT;
                    end
                end
                // spare state after the multiply/divide writeback
                ST_WAIT: r_st <= ST_OUT;
                ST_OUT:  if (i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/rv32im_execute_core_top.sv @@
// rv32im execute core: multiply, divide and remainder run in a separate unit with a 32-step divider;
// divide by zero skips the divider steps
// one transaction in the back end at a time; a two-entry input queue keeps accepting
// while a result waits; the back end takes the next item only after the last result, if any, is accepted
// synchronous active-low reset clears the pc to zero, registers read as zero, no halt
// depends on rvx_pkg, rvx_front, rvx_back
module rv32im_execute_core_top import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_mem_rdata,
    input  logic        i_mem_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_halt_cause,
    output logic [31:0] o_next_pc,
    output logic [31:0] o_mem_addr,
    output logic        o_mem_is_write,
    output logic [1:0]  o_mem_size_log2,
    output logic [31:0] o_store_data
);

    logic    head_valid, pop;
    t_qent   head;
    t_result res;

    assign o_cfg_ready = 1'b1;

    rvx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_req_type   (i_req_type),
        .i_instr_word (i_instr_word),
        .i_mem_rdata  (i_mem_rdata),
        .i_mem_ok     (i_mem_ok),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    rvx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (res)
    );

    assign o_result_kind   = res.result_kind;
    assign o_halt_cause    = res.halt_cause;
    assign o_next_pc       = res.next_pc;
    assign o_mem_addr      = res.mem_addr;
    assign o_mem_is_write  = res.mem_is_write;
    assign o_mem_size_log2 = res.mem_size_log2;
    assign o_store_data    = res.store_data;

endmodule
